// ===== rtl/core/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared constants, codes and the configuration bundle of the tuner slot
// allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int POOLS         = 6;
  localparam int DEF_MAX_SLOTS = 8;
  localparam int COUNT_W       = 4;
  localparam int FILTER_W      = 32;
  localparam int DEV_W         = 8;
  localparam int OP_W          = 2;
  localparam int KIND_W        = 3;
  localparam int POOL_W        = 3;
  localparam int SLOT_OUT_W    = 3;
  localparam int REG_ADDR_W    = 3;

  localparam logic [OP_W-1:0] OP_ASSIGN = 2'd0;
  localparam logic [OP_W-1:0] OP_ATTACH = 2'd1;
  localparam logic [OP_W-1:0] OP_DETACH = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SAT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TERR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CABLE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ATSC  = 3'd3;

  localparam logic [POOL_W-1:0] POOL_S2   = 3'd0;
  localparam logic [POOL_W-1:0] POOL_T    = 3'd1;
  localparam logic [POOL_W-1:0] POOL_T2   = 3'd2;
  localparam logic [POOL_W-1:0] POOL_C    = 3'd3;
  localparam logic [POOL_W-1:0] POOL_C2   = 3'd4;
  localparam logic [POOL_W-1:0] POOL_ATSC = 3'd5;

  localparam logic [REG_ADDR_W-1:0] REG_FILTER_FIRST  = 3'd6;
  localparam logic [REG_ADDR_W-1:0] REG_FILTER_SECOND = 3'd7;

  typedef struct packed {
    logic [POOLS-1:0][COUNT_W-1:0] count;
    logic [FILTER_W-1:0]           filter_first;
    logic [FILTER_W-1:0]           filter_second;
    logic [POOLS-1:0]              clear;
  } cfg_t;

endpackage

// ===== rtl/core/tsa_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tsa_cfg_regs
// Pool count and source filter registers with per-pool clear strobes.
// ----------------------------------------------------------------------------
module tsa_cfg_regs
  import tsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [REG_ADDR_W-1:0] cfg_addr,
  input  logic [FILTER_W-1:0]   cfg_wdata,
  output cfg_t                  cfg_o
);

  logic [POOLS-1:0][COUNT_W-1:0] count_r;
  logic [FILTER_W-1:0]           filt_first_r;
  logic [FILTER_W-1:0]           filt_second_r;
  logic [POOLS-1:0]              clear;

  always_comb begin
    clear = '0;
    for (int p = 0; p < POOLS; p++) begin
      if (cfg_we && (cfg_addr == REG_ADDR_W'(p))) begin
        clear[p] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      filt_first_r  <= '0;
      filt_second_r <= '0;
    end else begin
      for (int p = 0; p < POOLS; p++) begin
        if (clear[p]) begin
          count_r[p] <= cfg_wdata[COUNT_W-1:0];
        end
      end
      if (cfg_we && (cfg_addr == REG_FILTER_FIRST)) begin
        filt_first_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_addr == REG_FILTER_SECOND)) begin
        filt_second_r <= cfg_wdata;
      end
    end
  end

  assign cfg_o.count         = count_r;
  assign cfg_o.filter_first  = filt_first_r;
  assign cfg_o.filter_second = filt_second_r;
  assign cfg_o.clear         = clear;

endmodule

// ===== rtl/core/tuner_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// tuner_slot_allocator
// Six pools of tuner slots; assign, attach and detach requests walk the
// slot owner memory one slot per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake; in_tuser carries the op code, in_tdata
//           the device, source code, source kind and second-generation flag.
//   out_* : one result per request; out_tuser is the ok flag, out_tdata the
//           pool and slot (both zero on failure).
//   cfg_* : write-only registers: six pool counts, then two filter codes.
//           Writing a pool count frees every slot of that pool.
// Timing: a request walks each pool it visits through the owner memory, one
//   read issued per cycle, then passes its result through the hold state.
//   Assign visits at most two pools, attach and detach up to six. The
//   registered owner memory read sets the pace of the walk.
// Reset clears all counts, filters and slot marks; the block is ready at
//   once. A stalled result holds in the output register while the next
//   request is accepted; that request's result waits until the output frees.
// ----------------------------------------------------------------------------
module tuner_slot_allocator
  import tsa_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
)(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: device_id[7:0], source_code[39:8], source_kind[42:40],
  //           second_gen[43], zero[47:44]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,
  // in_tuser: op[1:0]
  input  logic [OP_W-1:0]       in_tuser,
  // out_tdata: pool_index[2:0], slot_index[5:3], zero[7:6]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  // out_tuser: ok[0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [REG_ADDR_W-1:0] cfg_addr,
  input  logic [FILTER_W-1:0]   cfg_wdata
);

  localparam int TOTAL = POOLS * MAX_SLOTS;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int IW    = $clog2(MAX_SLOTS + 1);
  localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW    = (IW > COUNT_W) ? IW : COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  cfg_t cfg;

  tsa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  logic [DEV_W-1:0]      in_dev;
  logic [FILTER_W-1:0]   in_src;
  logic [KIND_W-1:0]     in_kind;
  logic                  in_gen2;

  assign in_dev  = in_tdata[7:0];
  assign in_src  = in_tdata[39:8];
  assign in_kind = in_tdata[42:40];
  assign in_gen2 = in_tdata[43];

  logic [1:0]            state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [DEV_W-1:0]      dev_r, dev_nxt;
  logic [POOL_W-1:0]     pool_r, pool_nxt;
  logic                  fb_v_r, fb_v_nxt;
  logic [POOL_W-1:0]     fb_pool_r, fb_pool_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic                  rd_v_r, rd_v_nxt;
  logic [AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic [SW-1:0]         rd_slot_r, rd_slot_nxt;
  logic                  free_v_r, free_v_nxt;
  logic [SW-1:0]         free_slot_r, free_slot_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [POOL_W-1:0]     res_pool_r, res_pool_nxt;
  logic [SLOT_OUT_W-1:0] res_slot_r, res_slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [POOL_W-1:0]     out_pool_r, out_pool_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [TOTAL-1:0]      used_r, used_nxt;
  logic [TOTAL-1:0]      att_r, att_nxt;

  logic [DEV_W-1:0]      owner_mem [TOTAL];
  logic [DEV_W-1:0]      mem_q_r;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;

  logic                  filt_pass;
  logic [CW-1:0]         cnt_ext;
  logic [CW-1:0]         n_act;
  logic                  hit;
  logic                  free_now;
  logic                  free_any;
  logic [SW-1:0]         free_sel;
  logic                  more;

  function automatic logic [AW-1:0] slot_addr(logic [POOL_W-1:0] p, logic [SW-1:0] s);
    slot_addr = AW'(p) * AW'(MAX_SLOTS) + AW'(s);
  endfunction

  assign filt_pass = (cfg.filter_first == '0) || (in_src == cfg.filter_first) ||
                     (in_src == cfg.filter_second);

  assign cnt_ext  = CW'(cfg.count[pool_r]);
  assign n_act    = (cnt_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : cnt_ext;
  assign more     = CW'(i_r) < n_act;
  assign hit      = rd_v_r && used_r[rd_addr_r] && (mem_q_r == dev_r);
  assign free_now = rd_v_r && !used_r[rd_addr_r];
  assign free_any = free_v_r || free_now;
  assign free_sel = free_v_r ? free_slot_r : rd_slot_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {2'b00, out_slot_r, out_pool_r};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dev_nxt       = dev_r;
    pool_nxt      = pool_r;
    fb_v_nxt      = fb_v_r;
    fb_pool_nxt   = fb_pool_r;
    i_nxt         = i_r;
    rd_v_nxt      = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    rd_slot_nxt   = rd_slot_r;
    free_v_nxt    = free_v_r;
    free_slot_nxt = free_slot_r;
    res_ok_nxt    = res_ok_r;
    res_pool_nxt  = res_pool_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_pool_nxt  = out_pool_r;
    out_slot_nxt  = out_slot_r;
    used_nxt      = used_r;
    att_nxt       = att_r;
    mem_re        = 1'b0;
    mem_raddr     = slot_addr(pool_r, i_r[SW-1:0]);
    mem_we        = 1'b0;
    mem_waddr     = slot_addr(pool_r, free_sel);

    for (int p = 0; p < POOLS; p++) begin
      if (cfg.clear[p]) begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
          used_nxt[p*MAX_SLOTS + s] = 1'b0;
          att_nxt[p*MAX_SLOTS + s]  = 1'b0;
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser;
          dev_nxt      = in_dev;
          fb_v_nxt     = 1'b0;
          i_nxt        = '0;
          free_v_nxt   = 1'b0;
          res_ok_nxt   = 1'b0;
          res_pool_nxt = '0;
          res_slot_nxt = '0;
          state_nxt    = ST_HOLD;
          priority case (1'b1)
            (in_tuser == OP_ASSIGN) && filt_pass && (in_kind == KIND_SAT): begin
              pool_nxt  = POOL_S2;
              state_nxt = ST_SCAN;
            end
            (in_tuser == OP_ASSIGN) && filt_pass && (in_kind == KIND_TERR): begin
              pool_nxt    = in_gen2 ? POOL_T2 : POOL_T;
              fb_v_nxt    = !in_gen2;
              fb_pool_nxt = POOL_T2;
              state_nxt   = ST_SCAN;
            end
            (in_tuser == OP_ASSIGN) && filt_pass && (in_kind == KIND_CABLE): begin
              pool_nxt    = in_gen2 ? POOL_C2 : POOL_C;
              fb_v_nxt    = !in_gen2;
              fb_pool_nxt = POOL_C2;
              state_nxt   = ST_SCAN;
            end
            (in_tuser == OP_ASSIGN) && filt_pass && (in_kind == KIND_ATSC): begin
              pool_nxt  = POOL_ATSC;
              state_nxt = ST_SCAN;
            end
            (in_tuser == OP_ATTACH) || (in_tuser == OP_DETACH): begin
              pool_nxt  = POOL_S2;
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_HOLD;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (free_now && !free_v_r) begin
          free_v_nxt    = 1'b1;
          free_slot_nxt = rd_slot_r;
        end
        if (hit) begin
          res_ok_nxt   = 1'b1;
          res_pool_nxt = pool_r;
          res_slot_nxt = SLOT_OUT_W'(rd_slot_r);
          state_nxt    = ST_HOLD;
          if (op_r == OP_ATTACH) begin
            att_nxt[rd_addr_r] = 1'b1;
          end else if (op_r == OP_DETACH) begin
            att_nxt[rd_addr_r]  = 1'b0;
            used_nxt[rd_addr_r] = 1'b0;
          end
        end else if (more) begin
          mem_re      = 1'b1;
          rd_v_nxt    = 1'b1;
          rd_addr_nxt = mem_raddr;
          rd_slot_nxt = i_r[SW-1:0];
          i_nxt       = i_r + IW'(1);
        end else begin
          i_nxt      = '0;
          free_v_nxt = 1'b0;
          if ((op_r == OP_ASSIGN) && free_any) begin
            mem_we              = 1'b1;
            used_nxt[mem_waddr] = 1'b1;
            res_ok_nxt          = 1'b1;
            res_pool_nxt        = pool_r;
            res_slot_nxt        = SLOT_OUT_W'(free_sel);
            state_nxt           = ST_HOLD;
          end else if ((op_r == OP_ASSIGN) && fb_v_r) begin
            pool_nxt = fb_pool_r;
            fb_v_nxt = 1'b0;
          end else if ((op_r != OP_ASSIGN) && (pool_r != POOL_ATSC)) begin
            pool_nxt = pool_r + POOL_W'(1);
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end

      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_pool_nxt  = res_pool_r;
          out_slot_nxt  = res_slot_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[mem_waddr] <= dev_r;
    end
    if (mem_re) begin
      mem_q_r <= owner_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      free_v_r    <= 1'b0;
      fb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      att_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      free_v_r    <= free_v_nxt;
      fb_v_r      <= fb_v_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      att_r       <= att_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    dev_r       <= dev_nxt;
    pool_r      <= pool_nxt;
    fb_pool_r   <= fb_pool_nxt;
    i_r         <= i_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_slot_r   <= rd_slot_nxt;
    free_slot_r <= free_slot_nxt;
    res_ok_r    <= res_ok_nxt;
    res_pool_r  <= res_pool_nxt;
    res_slot_r  <= res_slot_nxt;
    out_ok_r    <= out_ok_nxt;
    out_pool_r  <= out_pool_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  a_att_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
    (att_r & ~used_r) == '0)
    else $error("attached slot is not in use");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> state_r == ST_SCAN)
    else $error("owner read in flight outside scan");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed result carries nonzero pool or slot");

endmodule
